// ===== src/icr_pkg.sv =====
`timescale 1ns / 1ps
// Package for the integer to ASCII converter: widths, character codes, register map,
// base limits, shared structs, the base clamp and the digit-to-character function.
// Depends on nothing; every other file of the block imports it.
package icr_pkg;

	// Field and port widths.
	localparam int VALUE_W        = 32;
	localparam int CHAR_W         = 8;
	localparam int DIGIT_W        = 6;
	localparam int RADIX_W        = 6;
	localparam int ADDR_W         = 3;
	localparam int DATA_W         = 32;
	localparam int DEF_VALUE_BITS = 32;

	// Register map: word index taken from paddr above the byte offset.
	localparam logic REG_RADIX = 1'b0;

	// Base limits and defaults.
	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [RADIX_W-1:0] DEC_BASE    = 6'd10;

	// Character codes.
	localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_ALPHA = 8'h37;
	localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;

	// One digit coming out of the divider.
	typedef struct packed {
		logic               valid;
		logic               is_last;
		logic [DIGIT_W-1:0] digit;
	} digit_t;

	// Commands from the sequencer to the character emitter.
	typedef struct packed {
		logic clear;
		logic play;
		logic neg;
	} emit_ctl_t;

	// Clamp the configured base to the legal range.
	function automatic logic [RADIX_W-1:0] sat_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] res;
		res = r;
		if (r < RADIX_MIN) begin
			res = RADIX_MIN;
		end else if (r > RADIX_MAX) begin
			res = RADIX_MAX;
		end
		return res;
	endfunction

	// Map a digit value to '0'..'9' or 'A'..'Z'.
	function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] res;
		if (d < DIGIT_W'(10)) begin
			res = CHAR_ZERO + CHAR_W'(d);
		end else begin
			res = CHAR_ALPHA + CHAR_W'(d);
		end
		return res;
	endfunction

endpackage

// ===== src/icr_if.sv =====
`timescale 1ns / 1ps
// Valid/ready channel interfaces for the number input and the character output.
// Depends on icr_pkg for the payload widths.

// Number channel: one item is one number with its signed flag.
interface icr_in_if import icr_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [VALUE_W-1:0] value;
	logic               is_signed;

	modport source(output valid, value, is_signed, input ready);
	modport sink(input valid, value, is_signed, output ready);
endinterface

// Character channel: one item is one character with its last-of-number flag.
interface icr_out_if import icr_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [CHAR_W-1:0] out_char;
	logic              last;

	modport source(output valid, out_char, last, input ready);
	modport sink(input valid, out_char, last, output ready);
endinterface

// ===== src/icr_div.sv =====
`timescale 1ns / 1ps
// Bit-serial restoring divider: divides the number by the base one bit per cycle and
// keeps dividing the quotient until it is zero, giving one digit per pass, lowest first.
// Depends on icr_pkg.
module icr_div import icr_pkg::*; #(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	input  logic [VALUE_BITS-1:0] value,
	input  logic [RADIX_W-1:0]    base,
	output digit_t                dig
);

	localparam int CW = $clog2(VALUE_BITS);

	logic                  busy_q;
	logic                  nz_q;
	logic [CW-1:0]         cnt_q;
	logic [VALUE_BITS-1:0] q_q;
	logic [DIGIT_W-1:0]    r_q;
	logic [RADIX_W-1:0]    base_q;

	logic [DIGIT_W:0]      rs;
	logic                  ge;
	logic [DIGIT_W-1:0]    rn;
	logic [VALUE_BITS-1:0] qn;
	logic                  nz_n;
	logic                  pass_end;

	// One restoring step: shift in the next dividend bit, subtract the base if it fits.
	always_comb begin
		rs       = {r_q, q_q[VALUE_BITS-1]};
		ge       = (rs >= {1'b0, base_q});
		rn       = ge ? DIGIT_W'(rs - {1'b0, base_q}) : rs[DIGIT_W-1:0];
		qn       = {q_q[VALUE_BITS-2:0], ge};
		nz_n     = nz_q | ge;
		pass_end = busy_q && (cnt_q == CW'(VALUE_BITS - 1));
	end

	// Pass and bit counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			nz_q   <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			nz_q   <= 1'b0;
			cnt_q  <= '0;
		end else if (busy_q) begin
			if (pass_end) begin
				busy_q <= nz_n;
				nz_q   <= 1'b0;
				cnt_q  <= '0;
			end else begin
				nz_q  <= nz_n;
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// Quotient shift register and partial remainder.
	always_ff @(posedge clk) begin
		if (start) begin
			q_q    <= value;
			r_q    <= '0;
			base_q <= base;
		end else if (busy_q) begin
			q_q <= qn;
			r_q <= pass_end ? '0 : rn;
		end
	end

	// A digit is ready at the end of each pass; the last one leaves a zero quotient.
	assign dig.valid   = pass_end;
	assign dig.is_last = !nz_n;
	assign dig.digit   = rn;

endmodule

// ===== src/icr_emit.sv =====
`timescale 1ns / 1ps
// Digit stack and character emitter: stores digits lowest first, then plays them back
// highest first as ASCII, with an optional leading minus, through the output register.
// Depends on icr_pkg and icr_if.
module icr_emit import icr_pkg::*; #(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic      clk,
	input  logic      arst_n,
	input  digit_t    dig,
	input  emit_ctl_t ctl,
	output logic      done,
	icr_out_if.source text
);

	localparam int PW  = $clog2(VALUE_BITS);
	localparam int CNW = $clog2(VALUE_BITS + 1);

	typedef enum logic [3:0] {
		E_IDLE  = 4'b0001,
		E_SIGN  = 4'b0010,
		E_FETCH = 4'b0100,
		E_LOAD  = 4'b1000
	} emit_state_t;

	emit_state_t        state_q;
	logic [CNW-1:0]     cnt_q;
	logic [PW-1:0]      rd_ptr_q;
	logic [DIGIT_W-1:0] rd_data_q;
	logic [DIGIT_W-1:0] mem [VALUE_BITS];
	logic               o_valid_q;
	logic [CHAR_W-1:0]  o_char_q;
	logic               o_last_q;
	logic               out_free;
	logic               load_sign;
	logic               load_digit;

	assign out_free   = !o_valid_q || text.ready;
	assign load_sign  = (state_q == E_SIGN) && out_free;
	assign load_digit = (state_q == E_LOAD) && out_free;
	assign done       = load_digit && (rd_ptr_q == '0);

	// Digit memory: one write port for pushes, one registered read port for playback.
	always_ff @(posedge clk) begin
		if (dig.valid) begin
			mem[cnt_q[PW-1:0]] <= dig.digit;
		end
		if (state_q == E_FETCH) begin
			rd_data_q <= mem[rd_ptr_q];
		end
	end

	// Fill count and playback sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= E_IDLE;
			cnt_q    <= '0;
			rd_ptr_q <= '0;
		end else begin
			if (ctl.clear) begin
				cnt_q <= '0;
			end else if (dig.valid) begin
				cnt_q <= cnt_q + 1'b1;
			end
			case (state_q)
				E_IDLE: begin
					if (ctl.play) begin
						rd_ptr_q <= PW'(cnt_q - 1'b1);
						state_q  <= ctl.neg ? E_SIGN : E_FETCH;
					end
				end
				E_SIGN: begin
					if (out_free) begin
						state_q <= E_FETCH;
					end
				end
				E_FETCH: begin
					state_q <= E_LOAD;
				end
				E_LOAD: begin
					if (out_free) begin
						if (rd_ptr_q == '0) begin
							state_q <= E_IDLE;
						end else begin
							rd_ptr_q <= rd_ptr_q - 1'b1;
							state_q  <= E_FETCH;
						end
					end
				end
				default: begin
					state_q <= E_IDLE;
				end
			endcase
		end
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			o_valid_q <= 1'b0;
		end else if (load_sign || load_digit) begin
			o_valid_q <= 1'b1;
		end else if (text.ready) begin
			o_valid_q <= 1'b0;
		end
	end

	// Output register payload.
	always_ff @(posedge clk) begin
		if (load_sign) begin
			o_char_q <= CHAR_MINUS;
			o_last_q <= 1'b0;
		end else if (load_digit) begin
			o_char_q <= digit_char(rd_data_q);
			o_last_q <= (rd_ptr_q == '0);
		end
	end

	assign text.valid    = o_valid_q;
	assign text.out_char = o_char_q;
	assign text.last     = o_last_q;

endmodule

// ===== src/integer_to_ascii_radix.sv =====
`timescale 1ns / 1ps
// Top level of the integer to ASCII converter: register port, sequencer, divider, emitter.
// Depends on icr_pkg, icr_if, icr_div and icr_emit.
//
//   Channel  Dir  Handshake            Payload
//   num      in   valid/ready          value[31:0], is_signed
//   text     out  valid/ready          out_char[7:0], last
//   APB      in   psel/penable/pready  paddr, pwdata, prdata (radix at 0x0)
//
// Each digit takes one divider pass over all VALUE_BITS bits of the quotient, and each
// digit character goes through the emitter's fetch and load states. A 32-bit number takes
// at most 10 passes in decimal and up to 32 passes in base 2.
// A new number is accepted once its predecessor's last character is in the output register.
// arst_n clears the sequencers, the output valid flag and sets radix to 10.
// A stalled text channel holds the current character and pauses playback.
module integer_to_ascii_radix import icr_pkg::*; #(
	parameter int VALUE_BITS = DEF_VALUE_BITS
) (
	input  logic              clk,
	input  logic              arst_n,
	icr_in_if.sink            num,
	icr_out_if.source         text,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [DATA_W-1:0] pwdata,
	output logic [DATA_W-1:0] prdata,
	output logic              pready
);

	typedef enum logic [3:0] {
		T_IDLE   = 4'b0001,
		T_DIV    = 4'b0010,
		T_LAUNCH = 4'b0100,
		T_WAIT   = 4'b1000
	} top_state_t;

	top_state_t            state_q;
	logic [RADIX_W-1:0]    radix_q;
	logic                  neg_q;
	logic                  accept;
	logic [VALUE_BITS-1:0] v_in;
	logic                  neg;
	logic [VALUE_BITS-1:0] mag;
	logic [RADIX_W-1:0]    base;
	digit_t                dig;
	emit_ctl_t             ctl;
	logic                  emit_done;

	// Register port: one register, radix, at word index zero.
	assign pready = 1'b1;
	assign prdata = (paddr[ADDR_W-1] == REG_RADIX) ? DATA_W'(radix_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (psel && penable && pwrite && pready && paddr[ADDR_W-1] == REG_RADIX) begin
			radix_q <= pwdata[RADIX_W-1:0];
		end
	end

	// Operand setup: sign, magnitude and base.
	assign num.ready = (state_q == T_IDLE);
	assign accept    = num.valid && num.ready;

	always_comb begin
		v_in = VALUE_BITS'(num.value);
		neg  = num.is_signed && v_in[VALUE_BITS-1];
		mag  = neg ? (~v_in + 1'b1) : v_in;
		base = num.is_signed ? DEC_BASE : sat_radix(radix_q);
	end

	// Sequencer: divide, then start playback once the last digit is stored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= T_IDLE;
			neg_q   <= 1'b0;
		end else begin
			case (state_q)
				T_IDLE: begin
					if (accept) begin
						neg_q   <= neg;
						state_q <= T_DIV;
					end
				end
				T_DIV: begin
					if (dig.valid && dig.is_last) begin
						state_q <= T_LAUNCH;
					end
				end
				T_LAUNCH: begin
					state_q <= T_WAIT;
				end
				T_WAIT: begin
					if (emit_done) begin
						state_q <= T_IDLE;
					end
				end
				default: begin
					state_q <= T_IDLE;
				end
			endcase
		end
	end

	assign ctl.clear = accept;
	assign ctl.play  = (state_q == T_LAUNCH);
	assign ctl.neg   = neg_q;

	icr_div #(
		.VALUE_BITS(VALUE_BITS)
	) u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.start (accept),
		.value (mag),
		.base  (base),
		.dig   (dig)
	);

	icr_emit #(
		.VALUE_BITS(VALUE_BITS)
	) u_emit (
		.clk   (clk),
		.arst_n(arst_n),
		.dig   (dig),
		.ctl   (ctl),
		.done  (emit_done),
		.text  (text)
	);

	// The sequencer state is always a single one-hot code.
	a_state_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot(state_q))
		else $error("sequencer state not one-hot");

	// Digits arrive only while a division is in progress.
	a_digit_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		dig.valid |-> state_q == T_DIV)
		else $error("digit produced outside division");

	// A digit never reaches the largest base.
	a_digit_range: assert property (@(posedge clk) disable iff (!arst_n)
		dig.valid |-> dig.digit < RADIX_MAX)
		else $error("digit out of range");

	// Playback completes only after it was launched.
	a_done_in_wait: assert property (@(posedge clk) disable iff (!arst_n)
		emit_done |-> state_q == T_WAIT)
		else $error("playback done without launch");

endmodule

// ===== test/tb_integer_to_ascii_radix.sv =====
`timescale 1ns / 1ps
// Testbench for integer_to_ascii_radix: sends numbers over the input channel and checks each
// output character and its last flag against a predicted digit string, over several bases.
// Depends on icr_pkg, icr_if and the integer_to_ascii_radix RTL.
module tb_integer_to_ascii_radix;
	import icr_pkg::*;

	// Longest stretch without any handshake before the run is declared hung.
	localparam int QUIET_LIMIT = 20000;
	localparam int BATCH_ITEMS = 50;
	localparam int BATCH_COUNT = 8;
	localparam int TAIL_CYCLES = 40;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
	} text_char_t;

	typedef struct {
		logic [RADIX_W-1:0] radix;
		logic [VALUE_W-1:0] value;
		logic               is_signed;
		string              text;
	} number_row_t;

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic              pready;

	icr_in_if  num_ch();
	icr_out_if text_ch();

	integer_to_ascii_radix dut (
		.clk(clk),
		.arst_n(arst_n),
		.num(num_ch),
		.text(text_ch),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Shadow of the radix register and the characters still owed by the block.
	logic [RADIX_W-1:0] radix_shadow;
	text_char_t         pending_chars[$];
	string              typed_text[$];
	logic [CHAR_W-1:0]  spelled[$];
	number_row_t        directed_rows[$];
	int                 fault_count;
	bit                 src_gaps;
	bit                 sink_stalls;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// Spell a number as the block should: optional minus sign, then digits, most significant first.
	function automatic void spell_number(input logic [VALUE_W-1:0] v, input logic sgn,
			input logic [RADIX_W-1:0] rad);
		logic [VALUE_W-1:0] mag;
		logic [VALUE_W-1:0] base;
		logic [VALUE_W-1:0] dgt;
		logic [CHAR_W-1:0]  digits[$];
		mag = v;
		spelled.delete();
		if (sgn) begin
			base = VALUE_W'(DEC_BASE);
			if (v[VALUE_W-1]) begin
				spelled.push_back(CHAR_MINUS);
				mag = -v;
			end
		end else if (rad < RADIX_MIN) begin
			base = VALUE_W'(RADIX_MIN);
		end else if (rad > RADIX_MAX) begin
			base = VALUE_W'(RADIX_MAX);
		end else begin
			base = VALUE_W'(rad);
		end
		do begin
			dgt = mag % base;
			mag = mag / base;
			if (dgt < VALUE_W'(DEC_BASE)) begin
				digits.push_front(CHAR_ZERO + CHAR_W'(dgt));
			end else begin
				digits.push_front(CHAR_ALPHA + CHAR_W'(dgt));
			end
		end while (mag != 0);
		foreach (digits[i]) begin
			spelled.push_back(digits[i]);
		end
	endfunction

	function automatic void add_row(input logic [RADIX_W-1:0] r, input logic [VALUE_W-1:0] v,
			input logic sgn, input string s);
		number_row_t row;
		row.radix = r;
		row.value = v;
		row.is_signed = sgn;
		row.text = s;
		directed_rows.push_back(row);
	endfunction

	// Random numbers weighted toward sign boundaries, short strings and powers of two.
	function automatic logic [VALUE_W-1:0] pick_value();
		logic [VALUE_W-1:0] r;
		logic [VALUE_W-1:0] res;
		r = $urandom;
		case ($urandom_range(0, 9))
			4, 5: res = r >> $urandom_range(0, VALUE_W - 1);
			6: res = VALUE_W'($urandom_range(0, 40));
			7: begin
				case ($urandom_range(0, 5))
					0: res = '0;
					1: res = VALUE_W'(1);
					2: res = {1'b0, {(VALUE_W-1){1'b1}}};
					3: res = {1'b1, {(VALUE_W-1){1'b0}}};
					4: res = {1'b1, {(VALUE_W-2){1'b0}}, 1'b1};
					default: res = '1;
				endcase
			end
			8: res = r | {1'b1, {(VALUE_W-1){1'b0}}};
			9: res = (VALUE_W'(1) << $urandom_range(0, VALUE_W - 1)) - VALUE_W'($urandom_range(0, 1));
			default: res = r;
		endcase
		return res;
	endfunction

	// Offer one number, with an occasional gap before it.
	task automatic offer_number(input logic [VALUE_W-1:0] v, input logic sgn, input string typed);
		if (src_gaps && $urandom_range(0, 3) == 0) begin
			num_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 10)) @(posedge clk);
		end
		typed_text.push_back(typed);
		num_ch.valid <= 1'b1;
		num_ch.value <= v;
		num_ch.is_signed <= sgn;
		do @(posedge clk); while (!num_ch.ready);
	endtask

	// Stop sending and wait until every owed character has come out.
	task automatic wait_drained();
		num_ch.valid <= 1'b0;
		do @(posedge clk); while (pending_chars.size() != 0);
	endtask

	// Register write: setup phase, then access phase until pready.
	task automatic write_radix(input logic [RADIX_W-1:0] r);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= ADDR_W'({REG_RADIX, 2'b00});
		pwdata <= DATA_W'(r);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		radix_shadow = r;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// On each accepted number, queue the characters it should produce.
	always @(posedge clk) begin : take_numbers
		string      typed;
		text_char_t tc;
		if (arst_n && num_ch.valid && num_ch.ready) begin
			typed = typed_text.pop_front();
			if (typed.len() != 0) begin
				spelled.delete();
				for (int i = 0; i < typed.len(); i++) begin
					spelled.push_back(typed[i]);
				end
			end else begin
				spell_number(num_ch.value, num_ch.is_signed, radix_shadow);
			end
			foreach (spelled[i]) begin
				tc.ch = spelled[i];
				tc.last = (i == spelled.size() - 1);
				pending_chars.push_back(tc);
			end
		end
	end

	// Compare each accepted character with the oldest owed one.
	always @(posedge clk) begin : check_text
		text_char_t want;
		if (arst_n && text_ch.valid && text_ch.ready) begin
			if (pending_chars.size() == 0) begin
				$display("%0t: unexpected character, expected none, got %h last %b",
					$time, text_ch.out_char, text_ch.last);
				fault_count++;
			end else begin
				want = pending_chars.pop_front();
				if (text_ch.out_char !== want.ch) begin
					$display("%0t: out_char mismatch, expected %h got %h",
						$time, want.ch, text_ch.out_char);
					fault_count++;
				end
				if (text_ch.last !== want.last) begin
					$display("%0t: last mismatch, expected %b got %b",
						$time, want.last, text_ch.last);
					fault_count++;
				end
			end
		end
	end

	// Receiver stalls in bursts while enabled.
	initial begin : drive_ready
		int hold;
		hold = 0;
		text_ch.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold > 0) begin
				hold--;
			end else if (sink_stalls && $urandom_range(0, 5) == 0) begin
				text_ch.ready <= 1'b0;
				hold = $urandom_range(0, 9);
			end else begin
				text_ch.ready <= 1'b1;
			end
		end
	end

	// Hang detection: too many cycles without any handshake.
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((num_ch.valid && num_ch.ready) || (text_ch.valid && text_ch.ready) || psel) begin
				quiet = 0;
			end else begin
				quiet++;
			end
		end
		$display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
		$display("status: fail");
		$finish;
	end

	initial begin : run
		logic [RADIX_W-1:0] r;
		arst_n <= 1'b0;
		num_ch.valid <= 1'b0;
		num_ch.value <= '0;
		num_ch.is_signed <= 1'b0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		radix_shadow = RADIX_RESET;
		fault_count = 0;
		src_gaps = 1'b1;
		sink_stalls = 1'b1;

		// Directed numbers: radix, value, signed flag, and the string where it is obvious.
		add_row(RADIX_RESET, 32'h0000_0000, 1'b0, "0");
		add_row(RADIX_RESET, 32'h0000_0000, 1'b1, "0");
		add_row(RADIX_RESET, 32'h0000_0009, 1'b0, "9");
		add_row(RADIX_RESET, 32'h0000_000A, 1'b0, "10");
		add_row(RADIX_RESET, 32'hFFFF_FFFF, 1'b0, "4294967295");
		add_row(RADIX_RESET, 32'hFFFF_FFFF, 1'b1, "-1");
		add_row(RADIX_RESET, 32'h8000_0000, 1'b1, "-2147483648");
		add_row(RADIX_RESET, 32'h7FFF_FFFF, 1'b1, "2147483647");
		add_row(RADIX_RESET, 32'h8000_0000, 1'b0, "2147483648");
		add_row(RADIX_RESET, 32'h0000_3039, 1'b1, "12345");
		add_row(RADIX_MIN, 32'hFFFF_FFFF, 1'b0, "11111111111111111111111111111111");
		add_row(RADIX_MIN, 32'h0000_0000, 1'b0, "0");
		add_row(RADIX_MIN, 32'h8000_0000, 1'b0, "");
		add_row(RADIX_MIN, 32'h8000_0000, 1'b1, "-2147483648");
		add_row(6'd16, 32'hDEAD_BEEF, 1'b0, "DEADBEEF");
		add_row(6'd16, 32'hFFFF_FFFF, 1'b0, "FFFFFFFF");
		add_row(RADIX_MAX, 32'hFFFF_FFFF, 1'b0, "");
		add_row(RADIX_MAX, 32'h0000_0023, 1'b0, "Z");
		add_row(RADIX_MAX, 32'h0000_0024, 1'b0, "10");
		add_row(6'd0, 32'h0000_0005, 1'b0, "101");
		add_row(6'd1, 32'h0000_0002, 1'b0, "10");
		add_row(6'd37, 32'h0000_0023, 1'b0, "Z");
		add_row(6'd63, 32'h0000_0047, 1'b0, "1Z");
		add_row(6'd63, 32'hFFFF_FFF6, 1'b1, "-10");

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Walk the directed table, changing the base only once the block has gone quiet.
		foreach (directed_rows[i]) begin
			if (directed_rows[i].radix != radix_shadow) begin
				wait_drained();
				write_radix(directed_rows[i].radix);
			end
			offer_number(directed_rows[i].value, directed_rows[i].is_signed, directed_rows[i].text);
		end

		// Random batches, each under its own base; the last batch runs without idling.
		for (int b = 0; b < BATCH_COUNT; b++) begin
			case (b)
				0: r = RADIX_MIN;
				1: r = RADIX_MAX;
				2: r = '0;
				3: r = '1;
				4: r = 6'd16;
				7: r = DEC_BASE;
				default: r = RADIX_W'($urandom_range(0, 63));
			endcase
			src_gaps = (b != 4) && (b != BATCH_COUNT - 1);
			sink_stalls = src_gaps;
			wait_drained();
			write_radix(r);
			repeat (BATCH_ITEMS) begin
				offer_number(pick_value(), 1'($urandom_range(0, 1)), "");
			end
		end

		wait_drained();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (fault_count == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
src/icr_pkg.sv
src/icr_if.sv
src/icr_div.sv
src/icr_emit.sv
src/integer_to_ascii_radix.sv
test/tb_integer_to_ascii_radix.sv
